/* rtl/core/alc_pkg.sv */
`timescale 1ns / 1ps

package alc_pkg;

    // field and datapath widths
    localparam int CNT_W      = 16;
    localparam int SCALE_W    = 19;
    localparam int MULS_W     = CNT_W + SCALE_W;
    localparam int CH_W       = 22;
    localparam int CH_SHIFT   = 10;
    localparam int NUM_SHIFT  = 10;
    localparam int QUO_W      = 12;
    localparam int REM_W      = 34;
    localparam int RATIO_W    = 12;
    localparam int NSEG       = 8;
    localparam int SEG_W      = 3;
    localparam int COEF_W     = 10;
    localparam int PROD_W     = CH_W + COEF_W;
    localparam int LUX_SHIFT  = 14;
    localparam int LUX_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_ITIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PKG   = 2'd2;

    // channel scale factors, 10 fractional bits
    localparam logic [SCALE_W-1:0] SCALE_T13  = 19'h07517;
    localparam logic [SCALE_W-1:0] SCALE_T101 = 19'h00FE7;
    localparam logic [SCALE_W-1:0] SCALE_T402 = 19'h00400;

    // clip thresholds per integration time
    localparam logic [CNT_W-1:0] CLIP_T13  = 16'd4900;
    localparam logic [CNT_W-1:0] CLIP_T101 = 16'd37000;
    localparam logic [CNT_W-1:0] CLIP_T402 = 16'd65000;

    localparam logic [LUX_W-1:0]  SAT_LUX   = 17'd65536;
    localparam logic [PROD_W:0]   LUX_ROUND = (PROD_W + 1)'(1) << (LUX_SHIFT - 1);

    // segment tables: row 0 T/FN/CL package, row 1 chip-scale package
    localparam logic [COEF_W-1:0] SEG_K [2][NSEG] = '{
        '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
        '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
    };
    localparam logic [COEF_W-1:0] SEG_B [2][NSEG] = '{
        '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
        '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
    };
    localparam logic [COEF_W-1:0] SEG_M [2][NSEG] = '{
        '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
        '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
    };

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_BAD_TIME = 2'd2,
        STATUS_NEG      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ITIME_13MS  = 2'd0,
        ITIME_101MS = 2'd1,
        ITIME_402MS = 2'd2,
        ITIME_BAD   = 2'd3
    } itime_t;

    typedef struct packed {
        logic [CNT_W-1:0] broadband;
        logic [CNT_W-1:0] infrared;
    } in_item_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        status_t          status;
    } out_item_t;

    typedef struct packed {
        itime_t itime;
        logic   high_gain;
        logic   pkg;
    } cfg_t;

    // divider working set
    typedef struct packed {
        logic [CH_W-1:0]  ch0;
        logic [CH_W-1:0]  ch1;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        status_t          status;
        logic             pkg;
    } work_t;

    typedef struct packed {
        logic [CH_W-1:0]   ch0;
        logic [CH_W-1:0]   ch1;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
        status_t           status;
    } coef_t;

    typedef struct packed {
        logic [PROD_W-1:0] pos;
        logic [PROD_W-1:0] neg;
        status_t           status;
    } prod_t;

endpackage

/* rtl/core/alc_scale.sv */
`timescale 1ns / 1ps

module alc_scale
(
    input  logic                clk,
    input  logic                rst_n,
    input  alc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  alc_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output alc_pkg::work_t      out_data
);

    logic [alc_pkg::CNT_W-1:0]   clip;
    logic [alc_pkg::SCALE_W-1:0] scale;
    logic [alc_pkg::SCALE_W-1:0] scale_g;
    logic                        bad_time;
    logic                        sat;
    logic [alc_pkg::MULS_W-1:0]  mul0;
    logic [alc_pkg::MULS_W-1:0]  mul1;
    logic [alc_pkg::CH_W-1:0]    ch0;
    logic [alc_pkg::CH_W-1:0]    ch1;
    alc_pkg::work_t              data_next;
    alc_pkg::work_t              data_reg;
    logic                        valid_reg;

    // clip threshold and scale by integration time
    always_comb
    begin
        clip     = alc_pkg::CLIP_T402;
        scale    = alc_pkg::SCALE_T402;
        bad_time = 1'b0;
        unique case (cfg.itime)
            alc_pkg::ITIME_13MS:
            begin
                clip  = alc_pkg::CLIP_T13;
                scale = alc_pkg::SCALE_T13;
            end
            alc_pkg::ITIME_101MS:
            begin
                clip  = alc_pkg::CLIP_T101;
                scale = alc_pkg::SCALE_T101;
            end
            alc_pkg::ITIME_402MS:
            begin
                clip  = alc_pkg::CLIP_T402;
                scale = alc_pkg::SCALE_T402;
            end
            alc_pkg::ITIME_BAD:
            begin
                bad_time = 1'b1;
            end
        endcase
    end

    // 16x more at 1x gain
    assign scale_g = cfg.high_gain ? scale : (scale << 4);
    assign sat     = (in_data.broadband > clip) || (in_data.infrared > clip);

    // channel scaling
    assign mul0 = alc_pkg::MULS_W'(in_data.broadband) * alc_pkg::MULS_W'(scale_g);
    assign mul1 = alc_pkg::MULS_W'(in_data.infrared) * alc_pkg::MULS_W'(scale_g);
    assign ch0  = mul0[alc_pkg::CH_SHIFT +: alc_pkg::CH_W];
    assign ch1  = mul1[alc_pkg::CH_SHIFT +: alc_pkg::CH_W];

    always_comb
    begin
        data_next.ch0 = ch0;
        data_next.ch1 = ch1;
        data_next.rem = alc_pkg::REM_W'({ch1, {alc_pkg::NUM_SHIFT{1'b0}}});
        data_next.quo = '0;
        data_next.pkg = cfg.pkg;
        if (bad_time)
        begin
            data_next.status = alc_pkg::STATUS_BAD_TIME;
        end
        else if (sat)
        begin
            data_next.status = alc_pkg::STATUS_SAT;
        end
        else
        begin
            data_next.status = alc_pkg::STATUS_OK;
        end
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/alc_div_step.sv */
`timescale 1ns / 1ps

module alc_div_step
#(
    parameter int STEP = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  alc_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output alc_pkg::work_t out_data
);

    logic [alc_pkg::REM_W-1:0] dsh;
    logic                      fits;
    alc_pkg::work_t            data_next;
    alc_pkg::work_t            data_reg;
    logic                      valid_reg;

    // one restoring division step for quotient bit STEP
    assign dsh  = alc_pkg::REM_W'(in_data.ch0) << STEP;
    assign fits = in_data.rem >= dsh;

    always_comb
    begin
        data_next = in_data;
        if (fits)
        begin
            data_next.rem       = in_data.rem - dsh;
            data_next.quo[STEP] = 1'b1;
        end
    end

    // stage register
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/core/alc_seg_mul.sv */
`timescale 1ns / 1ps

module alc_seg_mul
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  alc_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output alc_pkg::prod_t out_data
);

    logic                        zero_div;
    logic                        quo_ovf;
    logic [alc_pkg::QUO_W:0]     quo_inc;
    logic [alc_pkg::RATIO_W-1:0] ratio;
    logic [alc_pkg::SEG_W-1:0]   seg;
    alc_pkg::coef_t              coef_next;
    alc_pkg::coef_t              coef_reg;
    logic                        coef_valid_reg;
    logic                        coef_ready;
    alc_pkg::prod_t              prod_next;
    alc_pkg::prod_t              prod_reg;
    logic                        prod_valid_reg;

    // ratio: zero divisor gives 0, a quotient past its width pins to the top
    assign zero_div = (in_data.ch0 == '0);
    assign quo_ovf  = ((alc_pkg::CH_W + 2)'(in_data.ch1)
                      >= ((alc_pkg::CH_W + 2)'(in_data.ch0) << 2));
    assign quo_inc  = (alc_pkg::QUO_W + 1)'(in_data.quo) + (alc_pkg::QUO_W + 1)'(1);

    always_comb
    begin
        if (zero_div)
        begin
            ratio = '0;
        end
        else if (quo_ovf)
        begin
            ratio = '1;
        end
        else
        begin
            ratio = quo_inc[alc_pkg::QUO_W:1];
        end
    end

    // first breakpoint at or above the ratio, last segment otherwise
    always_comb
    begin
        seg = alc_pkg::SEG_W'(alc_pkg::NSEG - 1);
        for (int s = alc_pkg::NSEG - 2; s >= 0; s--)
        begin
            if (ratio <= alc_pkg::RATIO_W'(alc_pkg::SEG_K[in_data.pkg][alc_pkg::SEG_W'(s)]))
            begin
                seg = alc_pkg::SEG_W'(s);
            end
        end
    end

    always_comb
    begin
        coef_next.ch0    = in_data.ch0;
        coef_next.ch1    = in_data.ch1;
        coef_next.b      = alc_pkg::SEG_B[in_data.pkg][seg];
        coef_next.m      = alc_pkg::SEG_M[in_data.pkg][seg];
        coef_next.status = in_data.status;
    end

    // segment stage register
    assign in_ready = !coef_valid_reg || coef_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            coef_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            coef_reg <= coef_next;
        end
    end

    // intercept and slope products
    always_comb
    begin
        prod_next.pos    = alc_pkg::PROD_W'(coef_reg.ch0) * alc_pkg::PROD_W'(coef_reg.b);
        prod_next.neg    = alc_pkg::PROD_W'(coef_reg.ch1) * alc_pkg::PROD_W'(coef_reg.m);
        prod_next.status = coef_reg.status;
    end

    // product stage register
    assign coef_ready = !prod_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (coef_ready)
        begin
            prod_valid_reg <= coef_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_valid_reg && coef_ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_data  = prod_reg;

endmodule

/* rtl/core/ambient_light_lux_calc.sv */
`timescale 1ns / 1ps

// Lux from one broadband/infrared photodiode count pair.
// Input channel: in_valid/in_stall with in_data (broadband, infrared).
// A request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with out_data (lux, status); one
// result per request, in request order.
// Config port: cfg_we/cfg_index/cfg_data, 0 integration time, 1 high gain,
// 2 chip-scale package; the user must write it only while no request is
// in flight, which the block does not enforce. Stages: one scaling stage,
// twelve divider stages (one quotient bit each for the ratio), a segment
// lookup stage, a multiply stage and the output register. One request
// per cycle is sustained while out_stall is low. Every stage holds its
// own valid bit, so bubbles close up and a stalled result does not block
// requests until the whole pipeline is full. When the receiver stalls,
// out_data holds and in_stall rises only once every stage is occupied.
// Reset clears all valid bits and sets integration time to 402 ms, 1x gain
// and the T/FN/CL table.
module ambient_light_lux_calc
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  alc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output alc_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [alc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NSTG = alc_pkg::QUO_W + 1;

    alc_pkg::itime_t            itime_reg;
    logic                       gain_reg;
    logic                       pkg_reg;
    alc_pkg::cfg_t              cfg;
    logic                       scale_ready;
    logic                       div_valid [NSTG];
    logic                       div_ready [NSTG];
    alc_pkg::work_t             div_data  [NSTG];
    logic                       prod_valid;
    logic                       prod_ready;
    alc_pkg::prod_t             prod_data;
    logic [alc_pkg::PROD_W:0]   lux_sum;
    alc_pkg::out_item_t         out_next;
    alc_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            itime_reg <= alc_pkg::ITIME_402MS;
            gain_reg  <= 1'b0;
            pkg_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                alc_pkg::REG_ITIME: itime_reg <= alc_pkg::itime_t'(cfg_data);
                alc_pkg::REG_GAIN:  gain_reg  <= cfg_data[0];
                alc_pkg::REG_PKG:   pkg_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.itime     = itime_reg;
        cfg.high_gain = gain_reg;
        cfg.pkg       = pkg_reg;
    end

    // clip check and channel scaling
    alc_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (scale_ready),
        .in_data   (in_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    assign in_stall = !scale_ready;

    // ratio divider, most significant quotient bit first
    for (genvar g = 0; g < alc_pkg::QUO_W; g++)
    begin : g_div
        alc_div_step
        #(
            .STEP (alc_pkg::QUO_W - 1 - g)
        )
        u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g + 1]),
            .out_ready (div_ready[g + 1]),
            .out_data  (div_data[g + 1])
        );
    end

    // segment lookup and products
    alc_seg_mul u_seg_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[NSTG - 1]),
        .in_ready  (div_ready[NSTG - 1]),
        .in_data   (div_data[NSTG - 1]),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // difference, rounding and status
    assign lux_sum = (alc_pkg::PROD_W + 1)'(prod_data.pos)
                   - (alc_pkg::PROD_W + 1)'(prod_data.neg)
                   + alc_pkg::LUX_ROUND;

    always_comb
    begin
        out_next.lux    = lux_sum[alc_pkg::LUX_SHIFT +: alc_pkg::LUX_W];
        out_next.status = prod_data.status;
        if (prod_data.status == alc_pkg::STATUS_SAT)
        begin
            out_next.lux = alc_pkg::SAT_LUX;
        end
        else if (prod_data.status == alc_pkg::STATUS_BAD_TIME)
        begin
            out_next.lux = '0;
        end
        else if (prod_data.neg > prod_data.pos)
        begin
            out_next.lux    = '0;
            out_next.status = alc_pkg::STATUS_NEG;
        end
    end

    // output register
    assign prod_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid && prod_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // input backpressure only comes from a stalled, occupied output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output");

    // a saturated result carries the saturation value
    a_sat_lux: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == alc_pkg::STATUS_SAT)
        |-> (out_data.lux == alc_pkg::SAT_LUX))
        else $error("saturated result with wrong lux");

    // error and clamped results report zero lux
    a_zero_lux: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status == alc_pkg::STATUS_BAD_TIME
                       || out_data.status == alc_pkg::STATUS_NEG))
        |-> (out_data.lux == '0))
        else $error("error or clamped result with nonzero lux");

    // a taken result with a valid product behind it is followed by another
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && prod_valid) |=> out_valid)
        else $error("pending result lost after output handoff");
`endif

endmodule
